### rtl/scf_pkg.sv
`default_nettype none

package scf_pkg;

	localparam int POS_BITS_DEF = 16;
	localparam int CFG_ADDR_W   = 5;
	localparam int CFG_DATA_W   = 32;

	// request codes
	typedef enum logic [1:0] {
		OP_STEP = 2'd0,
		OP_PAN  = 2'd1,
		OP_INIT = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		REG_MANUAL_DEFAULT = 3'd0,
		REG_TICK_PERIOD    = 3'd1,
		REG_STEP_LIMIT     = 3'd2,
		REG_LEAD_OFFSET    = 3'd3,
		REG_START_MARGIN   = 3'd4,
		REG_STOP_MARGIN    = 3'd5,
		REG_WINDOW_SIZE    = 3'd6,
		REG_PICTURE_EXTENT = 3'd7
	} reg_idx_t;

	localparam logic        RST_MANUAL_DEFAULT = 1'b0;
	localparam logic [7:0]  RST_TICK_PERIOD    = 8'd4;
	localparam logic [7:0]  RST_STEP_LIMIT     = 8'd4;
	localparam logic [9:0]  RST_LEAD_OFFSET    = 10'd80;
	localparam logic [9:0]  RST_START_MARGIN   = 10'd80;
	localparam logic [9:0]  RST_STOP_MARGIN    = 10'd4;
	localparam logic [14:0] RST_WINDOW_SIZE    = 15'd320;
	localparam logic [14:0] RST_PICTURE_EXTENT = 15'd320;

	typedef struct packed {
		logic        manual_default;
		logic [7:0]  tick_period;
		logic [7:0]  step_limit;
		logic [9:0]  lead_offset;
		logic [9:0]  start_margin;
		logic [9:0]  stop_margin;
		logic [14:0] window_size;
		logic [14:0] picture_extent;
	} cfg_t;

	typedef struct packed {
		logic        active;
		logic        manual;
		logic        heading_up;
		logic [31:0] next_time;
	} ctl_state_t;

endpackage

`default_nettype wire

### rtl/scf_item_if.sv
`default_nettype none

interface scf_item_if import scf_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF
) ();
	logic                       valid;
	logic                       ready;
	logic [1:0]                 op;
	logic [31:0]                now_time;
	logic [31:0]                prior_time;
	logic [7:0]                 tick_amount;
	logic signed [POS_BITS-1:0] view_pos;
	logic signed [POS_BITS-1:0] track_pos;
	logic signed [POS_BITS-1:0] goal_pos;

	modport source (
		output valid, op, now_time, prior_time, tick_amount, view_pos, track_pos, goal_pos,
		input  ready
	);
	modport sink (
		input  valid, op, now_time, prior_time, tick_amount, view_pos, track_pos, goal_pos,
		output ready
	);
endinterface

`default_nettype wire

### rtl/scf_result_if.sv
`default_nettype none

interface scf_result_if import scf_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF
) ();
	logic                       valid;
	logic                       ready;
	logic signed [POS_BITS-1:0] new_view;
	logic                       moved;
	logic                       panning_active;

	modport source (
		output valid, new_view, moved, panning_active,
		input  ready
	);
	modport sink (
		input  valid, new_view, moved, panning_active,
		output ready
	);
endinterface

`default_nettype wire

### rtl/scf_regs.sv
`default_nettype none

module scf_regs import scf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.manual_default <= RST_MANUAL_DEFAULT;
			cfg_q.tick_period    <= RST_TICK_PERIOD;
			cfg_q.step_limit     <= RST_STEP_LIMIT;
			cfg_q.lead_offset    <= RST_LEAD_OFFSET;
			cfg_q.start_margin   <= RST_START_MARGIN;
			cfg_q.stop_margin    <= RST_STOP_MARGIN;
			cfg_q.window_size    <= RST_WINDOW_SIZE;
			cfg_q.picture_extent <= RST_PICTURE_EXTENT;
		end else if (wr_en) begin
			unique case (idx)
				REG_MANUAL_DEFAULT: cfg_q.manual_default <= pwdata[0];
				REG_TICK_PERIOD:    cfg_q.tick_period    <= pwdata[7:0];
				REG_STEP_LIMIT:     cfg_q.step_limit     <= pwdata[7:0];
				REG_LEAD_OFFSET:    cfg_q.lead_offset    <= pwdata[9:0];
				REG_START_MARGIN:   cfg_q.start_margin   <= pwdata[9:0];
				REG_STOP_MARGIN:    cfg_q.stop_margin    <= pwdata[9:0];
				REG_WINDOW_SIZE:    cfg_q.window_size    <= pwdata[14:0];
				REG_PICTURE_EXTENT: cfg_q.picture_extent <= pwdata[14:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MANUAL_DEFAULT: prdata = CFG_DATA_W'(cfg_q.manual_default);
			REG_TICK_PERIOD:    prdata = CFG_DATA_W'(cfg_q.tick_period);
			REG_STEP_LIMIT:     prdata = CFG_DATA_W'(cfg_q.step_limit);
			REG_LEAD_OFFSET:    prdata = CFG_DATA_W'(cfg_q.lead_offset);
			REG_START_MARGIN:   prdata = CFG_DATA_W'(cfg_q.start_margin);
			REG_STOP_MARGIN:    prdata = CFG_DATA_W'(cfg_q.stop_margin);
			REG_WINDOW_SIZE:    prdata = CFG_DATA_W'(cfg_q.window_size);
			REG_PICTURE_EXTENT: prdata = CFG_DATA_W'(cfg_q.picture_extent);
		endcase
	end

endmodule

`default_nettype wire

### rtl/scf_step.sv
`default_nettype none

module scf_step import scf_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF
) (
	input  wire cfg_t                  cfg,
	input  wire ctl_state_t            st,
	input  wire logic signed [POS_BITS-1:0] goal,
	input  wire op_t                   op,
	input  wire logic [31:0]           now_time,
	input  wire logic [31:0]           prior_time,
	input  wire logic [7:0]            tick_amount,
	input  wire logic signed [POS_BITS-1:0] view_pos,
	input  wire logic signed [POS_BITS-1:0] track_pos,
	input  wire logic signed [POS_BITS-1:0] goal_pos,
	output ctl_state_t                 st_nxt,
	output logic signed [POS_BITS-1:0] goal_nxt,
	output logic signed [POS_BITS-1:0] new_view,
	output logic                       moved
);

	// room for a position plus picture extent and margins, with sign
	localparam int W = ((POS_BITS > 16) ? POS_BITS : 16) + 3;

	logic              allowed;
	logic [31:0]       tdiff;
	logic [31:0]       tmag;
	logic              align;
	logic [31:0]       gate_time;
	logic              gated;

	logic signed [W-1:0] view_w;
	logic signed [W-1:0] track_w;
	logic signed [W-1:0] goal_w;
	logic signed [W-1:0] win_w;
	logic signed [W-1:0] span_w;
	logic signed [W-1:0] sl_w;
	logic signed [W-1:0] lead_w;
	logic signed [W-1:0] stop_w;
	logic signed [W-1:0] lo_w;
	logic signed [W-1:0] hi_w;
	logic signed [W-1:0] mdiff;
	logic signed [W-1:0] mmag;
	logic signed [W-1:0] mclip;
	logic signed [W-1:0] aim;
	logic signed [W-1:0] fdiff;
	logic signed [W-1:0] fmag;
	logic signed [W-1:0] fclip;
	logic signed [W-1:0] step_w;

	assign allowed = cfg.picture_extent > cfg.window_size;

	// timer alignment to the tracked object's update time
	assign tdiff     = st.next_time - prior_time;
	assign tmag      = tdiff[31] ? (32'd0 - tdiff) : tdiff;
	assign align     = (tmag < 32'(cfg.tick_period)) && (tick_amount == cfg.tick_period);
	assign gate_time = align ? prior_time : st.next_time;
	assign gated     = st.active && (now_time < gate_time);

	assign view_w  = W'(view_pos);
	assign track_w = W'(track_pos);
	assign goal_w  = W'(goal);
	assign win_w   = W'(cfg.window_size);
	assign span_w  = W'(cfg.picture_extent) - win_w;
	assign sl_w    = W'(cfg.step_limit);
	assign lead_w  = W'(cfg.lead_offset);
	assign stop_w  = W'(cfg.stop_margin);
	assign lo_w    = view_w + W'(cfg.start_margin);
	assign hi_w    = view_w - W'(cfg.start_margin) + win_w - W'(1);

	assign mdiff = goal_w - view_w;
	assign mmag  = (mdiff < 0) ? -mdiff : mdiff;
	assign mclip = (mmag > sl_w) ? sl_w : mmag;

	always_comb begin
		st_nxt   = st;
		goal_nxt = goal;
		step_w   = '0;
		aim      = '0;
		fdiff    = '0;
		fmag     = '0;
		fclip    = '0;
		unique case (op)
			OP_INIT: begin
				st_nxt.active = 1'b0;
				if (allowed) begin
					st_nxt.manual    = cfg.manual_default;
					goal_nxt         = '0;
					st_nxt.next_time = now_time;
				end
			end
			OP_PAN: begin
				if (allowed) begin
					st_nxt.active    = 1'b1;
					st_nxt.manual    = 1'b1;
					goal_nxt         = goal_pos;
					st_nxt.next_time = now_time;
				end
			end
			OP_STEP: begin
				if (allowed && !gated) begin
					st_nxt.next_time = now_time + 32'(cfg.tick_period);
					if (st.manual) begin
						if (st.active) begin
							if (mclip == 0)
								st_nxt.active = 1'b0;
							else
								step_w = (mdiff < 0) ? -mclip : mclip;
						end
					end else begin
						// tracked object left the start window: begin panning
						if (!st.active) begin
							if (track_w < lo_w && view_w > 0) begin
								st_nxt.active     = 1'b1;
								st_nxt.heading_up = 1'b0;
							end
							if (track_w > hi_w && view_w < span_w) begin
								st_nxt.active     = 1'b1;
								st_nxt.heading_up = 1'b1;
							end
						end
						aim = track_w - (win_w >>> 1)
							+ (st_nxt.heading_up ? lead_w : -lead_w);
						if (aim < 0)
							aim = '0;
						if (aim > span_w)
							aim = span_w;
						goal_nxt = aim[POS_BITS-1:0];
						fdiff = aim - view_w;
						fmag  = (fdiff < 0) ? -fdiff : fdiff;
						fclip = (fmag > sl_w) ? sl_w : fmag;
						if (st_nxt.active && fmag <= stop_w)
							st_nxt.active = 1'b0;
						if (st_nxt.active)
							step_w = (fdiff < 0) ? -fclip : fclip;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign new_view = view_pos + step_w[POS_BITS-1:0];
	assign moved    = step_w != '0;

endmodule

`default_nettype wire

### rtl/scroll_follow_controller_core.sv
`default_nettype none

// One-axis viewport scroll controller. Each request (frame step, pan to a
// goal, or re-init) returns exactly one result: the new view origin, whether
// it moved, and the panning flag. Requests are taken one per clock unless the
// output stalls; a request lands in the input register when it is accepted
// and its result is loaded into the result register once that register is
// free or its result is being taken. The throughput of one request per cycle
// is set by the single combinational pass that updates the pan state and
// feeds it back for the next request. The result register lets a new request
// enter while a result is still waiting on the output.
// Configuration registers sit on the APB port at byte addresses 4*i and
// should be written only while the controller is idle.
module scroll_follow_controller_core import scf_pkg::*; #(
	parameter int POS_BITS = POS_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	scf_item_if.sink                   item,
	scf_result_if.source               result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	cfg_t cfg;

	logic                       valid_s1;
	logic [1:0]                 op_s1;
	logic [31:0]                now_time_s1;
	logic [31:0]                prior_time_s1;
	logic [7:0]                 tick_amount_s1;
	logic signed [POS_BITS-1:0] view_pos_s1;
	logic signed [POS_BITS-1:0] track_pos_s1;
	logic signed [POS_BITS-1:0] goal_pos_s1;

	ctl_state_t                 st_q;
	ctl_state_t                 st_nxt;
	logic signed [POS_BITS-1:0] goal_q;
	logic signed [POS_BITS-1:0] goal_nxt;

	logic                       res_valid_q;
	logic signed [POS_BITS-1:0] new_view_q;
	logic                       moved_q;
	logic                       active_q;
	logic signed [POS_BITS-1:0] new_view_c;
	logic                       moved_c;

	logic advance;
	logic take;

	scf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	scf_step #(.POS_BITS(POS_BITS)) u_step (
		.cfg         (cfg),
		.st          (st_q),
		.goal        (goal_q),
		.op          (op_t'(op_s1)),
		.now_time    (now_time_s1),
		.prior_time  (prior_time_s1),
		.tick_amount (tick_amount_s1),
		.view_pos    (view_pos_s1),
		.track_pos   (track_pos_s1),
		.goal_pos    (goal_pos_s1),
		.st_nxt      (st_nxt),
		.goal_nxt    (goal_nxt),
		.new_view    (new_view_c),
		.moved       (moved_c)
	);

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take       = item.valid && item.ready;

	assign result.valid          = res_valid_q;
	assign result.new_view       = new_view_q;
	assign result.moved          = moved_q;
	assign result.panning_active = active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			st_q        <= '0;
			goal_q      <= '0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance) begin
				res_valid_q <= 1'b1;
				st_q        <= st_nxt;
				goal_q      <= goal_nxt;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1          <= item.op;
			now_time_s1    <= item.now_time;
			prior_time_s1  <= item.prior_time;
			tick_amount_s1 <= item.tick_amount;
			view_pos_s1    <= item.view_pos;
			track_pos_s1   <= item.track_pos;
			goal_pos_s1    <= item.goal_pos;
		end
		if (advance) begin
			new_view_q <= new_view_c;
			moved_q    <= moved_c;
			active_q   <= st_nxt.active;
		end
	end

	a_init_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == OP_INIT |=> !st_q.active)
		else $error("re-init left panning active");

	a_moved_view: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> moved_q == (new_view_q != $past(view_pos_s1)))
		else $error("moved flag disagrees with view change");

	a_moved_active: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && moved_q |-> active_q)
		else $error("view moved while panning inactive");

	a_no_pan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !(cfg.picture_extent > cfg.window_size) && op_s1 != OP_INIT
		|=> $stable(st_q) && $stable(goal_q) && !moved_q)
		else $error("pan state changed while panning disabled");

endmodule

`default_nettype wire
